/* rtl/g711_pkg.sv */
// Shared types, constants and companding tables of the G.711 codec.
`default_nettype none

package g711_pkg;

  localparam int unsigned PCM_W      = 16;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned IDX_W      = 14;
  localparam int unsigned MAG_W      = 13;
  localparam int unsigned SRCH_W     = 7;
  localparam int unsigned SRCH_STEPS = SRCH_W;
  // Accept edge to the edge that takes the result word.
  localparam int unsigned RESULT_LAT = SRCH_STEPS + 1;

  localparam int unsigned THR_ENTRIES = 2 * (1 << SRCH_W);
  localparam int unsigned EXP_ENTRIES = 2 * (1 << CODE_W);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CODE_W-1:0] MU_BASE   = 8'hFF;
  localparam logic [CODE_W-1:0] A_BASE    = 8'hD5;
  localparam logic [CODE_W-1:0] A_XOR     = 8'h55;
  localparam logic [CODE_W-1:0] SIGN_FLIP = 8'h80;
  localparam logic [16:0]       MU_BIAS   = 17'h00084;
  localparam logic [IDX_W-1:0]  MID_INDEX = 14'd8192;
  localparam logic [SRCH_W-1:0] SRCH_MASK0 = 7'b1000000;

  typedef enum logic {
    LAW_MU = 1'b0,
    LAW_A  = 1'b1
  } law_e;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAW_SELECT = 1'b0,
    CFG_DIRECTION  = 1'b1
  } cfg_reg_e;

  // One word on its way down the search pipeline.
  typedef struct packed {
    logic              valid;
    law_e              law;
    dir_e              dir;
    logic              last;
    logic              mid;
    logic              positive;
    logic [MAG_W-1:0]  mag;
    logic [CODE_W-1:0] code;
    logic [SRCH_W-1:0] acc;
    logic [SRCH_W-1:0] mask;
  } srch_word_t;

  typedef logic [THR_ENTRIES-1:0][MAG_W-1:0] thr_tbl_t;
  typedef logic [EXP_ENTRIES-1:0][PCM_W-1:0] exp_tbl_t;

  // Expand one code to its linear level.
  function automatic logic [PCM_W-1:0] exp_level(input law_e law, input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] u;
    logic [2:0]        seg;
    logic [3:0]        m;
    logic [16:0]       t;
    logic [16:0]       v;
    if (law == LAW_A) begin
      u   = code ^ A_XOR;
      seg = u[6:4];
      m   = u[3:0];
      if (seg != 3'd0) begin
        t = (17'({m, 1'b1}) + 17'd32) << ({1'b0, seg} + 4'd2);
      end else begin
        t = 17'({m, 1'b1}) << 3;
      end
      v = u[7] ? t : (17'd0 - t);
    end else begin
      u   = ~code;
      seg = u[6:4];
      m   = u[3:0];
      t   = (17'({m, 3'b000}) + MU_BIAS) << seg;
      v   = u[7] ? (MU_BIAS - t) : (t - MU_BIAS);
    end
    return v[PCM_W-1:0];
  endfunction

  // Rounded midpoint between magnitude steps i and i+1, in index units.
  function automatic logic [MAG_W-1:0] thr_level(input law_e law, input logic [SRCH_W-1:0] i);
    logic [CODE_W-1:0] base;
    logic [PCM_W-1:0]  v1;
    logic [PCM_W-1:0]  v2;
    logic [16:0]       s;
    base = (law == LAW_A) ? A_BASE : MU_BASE;
    v1   = exp_level(law, {1'b0, i} ^ base);
    v2   = exp_level(law, ({1'b0, i} + 8'd1) ^ base);
    s    = 17'(v1) + 17'(v2) + 17'd4;
    return s[15:3];
  endfunction

  function automatic thr_tbl_t build_thr_tbl();
    thr_tbl_t          tbl;
    logic [SRCH_W:0]   a;
    for (int n = 0; n < THR_ENTRIES; n++) begin
      a      = (SRCH_W + 1)'(n);
      tbl[n] = thr_level(law_e'(a[SRCH_W]), a[SRCH_W-1:0]);
    end
    return tbl;
  endfunction

  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t          tbl;
    logic [CODE_W:0]   a;
    for (int n = 0; n < EXP_ENTRIES; n++) begin
      a      = (CODE_W + 1)'(n);
      tbl[n] = exp_level(law_e'(a[CODE_W]), a[CODE_W-1:0]);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

/* rtl/g711_srch_step.sv */
// One step of the pipelined threshold search, with its threshold ROM.
`default_nettype none

module g711_srch_step
  import g711_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  srch_word_t word_i,
  output srch_word_t word_o
);

  localparam thr_tbl_t THR_ROM = build_thr_tbl();

  logic              valid_q;
  srch_word_t        word_q;
  logic [MAG_W-1:0]  thr_q;
  logic [SRCH_W-1:0] rd_addr;
  logic              hit;

  // Probe the last threshold below the candidate step.
  assign rd_addr = word_i.acc | (word_i.mask - 7'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_i;
    thr_q  <= THR_ROM[{word_i.law, rd_addr}];
  end

  assign hit = (thr_q <= word_q.mag);

  always_comb begin
    word_o       = word_q;
    word_o.valid = valid_q;
    word_o.acc   = hit ? (word_q.acc | word_q.mask) : word_q.acc;
    word_o.mask  = word_q.mask >> 1;
  end

`ifndef SYNTHESIS
  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $onehot(word_q.mask))
    else $error("search mask not one-hot");

  a_acc_clear_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((word_q.acc & (7'(word_q.mask << 1) - 7'd1)) == '0))
    else $error("search step already set at or below its own bit");
`endif

endmodule

`default_nettype wire

/* rtl/g711_out_stage.sv */
// Result stage: expansion ROM for decode, code assembly for encode.
`default_nettype none

module g711_out_stage
  import g711_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  srch_word_t               word_i,
  output logic                     done_o,
  output logic [CODE_W-1:0]        code_o,
  output logic signed [PCM_W-1:0]  pcm_o,
  output logic                     last_o
);

  localparam exp_tbl_t EXP_ROM = build_exp_tbl();

  logic                    done_q;
  logic [CODE_W-1:0]       code_q;
  logic signed [PCM_W-1:0] pcm_q;
  logic                    last_q;
  logic [CODE_W-1:0]       base;
  logic [CODE_W-1:0]       enc;

  always_comb begin
    base = (word_i.law == LAW_A) ? A_BASE : MU_BASE;
    if (word_i.mid) begin
      enc = base;
    end else if (word_i.positive) begin
      enc = {1'b0, word_i.acc} ^ base;
    end else begin
      enc = {1'b0, word_i.acc} ^ base ^ SIGN_FLIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= word_i.last;
    if (word_i.dir == DIR_DECODE) begin
      pcm_q  <= EXP_ROM[{word_i.law, word_i.code}];
      code_q <= '0;
    end else begin
      pcm_q  <= '0;
      code_q <= enc;
    end
  end

  assign done_o = done_q;
  assign code_o = code_q;
  assign pcm_o  = pcm_q;
  assign last_o = last_q;

`ifndef SYNTHESIS
  a_one_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((code_q == '0) || (pcm_q == '0)))
    else $error("both result fields carry data");
`endif

endmodule

`default_nettype wire

/* rtl/g711_law_codec_unit.sv */
// Top level of the G.711 mu-law / A-law codec.
`default_nettype none

// Takes one sample word per cycle: busy is never raised, so a word is taken at
// every clock edge with start high. Each word gives one result, shown for one
// cycle with done_o high after the seven search step registers and the result
// stage register; the receiver must take it then. The latency is set by the
// seven-step binary search over the decision thresholds (one registered
// threshold ROM read per step) plus the registered result stage (expansion ROM
// for decode, code assembly for encode). No memory needs clearing after reset.
// Write law_select and direction only while no word is in flight.
module g711_law_codec_unit
  import g711_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic signed [PCM_W-1:0] pcm_in_i,
  input  logic [CODE_W-1:0]       code_in_i,
  input  logic                    last_in_i,
  output logic                    done_o,
  output logic [CODE_W-1:0]       code_out_o,
  output logic signed [PCM_W-1:0] pcm_out_o,
  output logic                    last_out_o
);

  law_e             law_q;
  dir_e             dir_q;
  logic [IDX_W-1:0] idx_raw;
  logic [IDX_W-1:0] idx;
  logic             positive;
  srch_word_t       word [SRCH_STEPS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_q <= LAW_MU;
      dir_q <= DIR_ENCODE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_LAW_SELECT: law_q <= law_e'(cfg_wdata_i[0]);
        CFG_DIRECTION:  dir_q <= dir_e'(cfg_wdata_i[0]);
      endcase
    end
  end

  // Offset-binary index; the bottom index folds onto the next one up.
  assign idx_raw  = {~pcm_in_i[PCM_W-1], pcm_in_i[PCM_W-2:2]};
  assign idx      = (idx_raw == '0) ? IDX_W'(1) : idx_raw;
  assign positive = (idx > MID_INDEX);

  always_comb begin
    word[0].valid    = start & ~busy;
    word[0].law      = law_q;
    word[0].dir      = dir_q;
    word[0].last     = last_in_i;
    word[0].mid      = (idx == MID_INDEX);
    word[0].positive = positive;
    word[0].mag      = positive ? MAG_W'(idx - MID_INDEX) : MAG_W'(MID_INDEX - idx);
    word[0].code     = code_in_i;
    word[0].acc      = '0;
    word[0].mask     = SRCH_MASK0;
  end

  for (genvar k = 0; k < SRCH_STEPS; k++) begin : g_srch
    g711_srch_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (word[k]),
      .word_o (word[k+1])
    );
  end

  g711_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (word[SRCH_STEPS]),
    .done_o (done_o),
    .code_o (code_out_o),
    .pcm_o  (pcm_out_o),
    .last_o (last_out_o)
  );

`ifndef SYNTHESIS
  a_word_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##RESULT_LAT done_o)
    else $error("accepted word gave no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, RESULT_LAT))
    else $error("result without an accepted word");

  a_search_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word[SRCH_STEPS].valid |-> (word[SRCH_STEPS].mask == '0))
    else $error("word left the search before all steps ran");
`endif

endmodule

`default_nettype wire

/* verif/g711_law_codec_unit_tb.sv */
// Self-checking testbench for the G.711 mu-law / A-law codec unit.
`timescale 1ns / 1ps

module g711_law_codec_unit_tb
  import g711_pkg::*;
;

  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned CYCLE_LIMIT     = 100000;

  typedef struct {
    logic [CODE_W-1:0]       code;
    logic signed [PCM_W-1:0] pcm;
    logic                    last;
  } codec_word_t;

  class codec_scoreboard;
    law_e          law;
    dir_e          dir;
    codec_word_t   expected_q[$];
    int unsigned   errors;

    function new();
      law    = LAW_MU;
      dir    = DIR_ENCODE;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic val);
      if (idx == CFG_LAW_SELECT) begin
        law = law_e'(val);
      end else begin
        dir = dir_e'(val);
      end
    endfunction

    // Linear level of one code.
    function int level(law_e sel, logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] u;
      int                t;
      if (sel == LAW_A) begin
        u = code ^ A_XOR;
        t = int'(u[3:0]);
        if (u[6:4] != 3'd0) begin
          t = (2 * t + 33) << (u[6:4] + 2);
        end else begin
          t = (2 * t + 1) << 3;
        end
        return u[7] ? t : -t;
      end
      u = ~code;
      t = ((int'(u[3:0]) << 3) + int'(MU_BIAS)) << u[6:4];
      return u[7] ? (int'(MU_BIAS) - t) : (t - int'(MU_BIAS));
    endfunction

    // Rounded midpoint between magnitude steps i and i+1, in index units.
    function int unsigned step_edge(law_e sel, logic [CODE_W-1:0] base, int i);
      int unsigned lo;
      int unsigned hi;
      lo = level(sel, CODE_W'(i) ^ base);
      hi = level(sel, CODE_W'(i + 1) ^ base);
      return (lo + hi + 4) >> 3;
    endfunction

    function logic [CODE_W-1:0] compress(law_e sel, logic signed [PCM_W-1:0] pcm);
      logic [CODE_W-1:0] base;
      logic [IDX_W-1:0]  idx;
      int                mag;
      int                i;
      logic              positive;
      base = (sel == LAW_A) ? A_BASE : MU_BASE;
      idx  = {~pcm[15], pcm[14:2]};
      // the bottom index folds onto its neighbour
      if (idx == '0) idx = IDX_W'(1);
      if (idx == MID_INDEX) return base;
      positive = idx > MID_INDEX;
      mag = positive ? (int'(idx) - int'(MID_INDEX)) : (int'(MID_INDEX) - int'(idx));
      for (i = 0; i < 127; i++) begin
        if (mag < int'(step_edge(sel, base, i))) break;
      end
      return CODE_W'(i) ^ base ^ (positive ? 8'h00 : SIGN_FLIP);
    endfunction

    function void note_word(logic signed [PCM_W-1:0] pcm, logic [CODE_W-1:0] code,
                            logic last);
      codec_word_t w;
      w.last = last;
      if (dir == DIR_DECODE) begin
        w.code = '0;
        w.pcm  = PCM_W'(level(law, code));
      end else begin
        w.code = compress(law, pcm);
        w.pcm  = '0;
      end
      expected_q.push_back(w);
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_word(logic [CODE_W-1:0] code, logic signed [PCM_W-1:0] pcm, logic last);
      codec_word_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word code=%02h pcm=%0d last=%0b", code, pcm, last));
      end else begin
        w = expected_q.pop_front();
        if (code !== w.code)
          report($sformatf("code_out %02h, want %02h", code, w.code));
        if (pcm !== w.pcm)
          report($sformatf("pcm_out %0d, want %0d", pcm, w.pcm));
        if (last !== w.last)
          report($sformatf("last_out %0b, want %0b", last, w.last));
      end
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    cfg_we_i;
  cfg_reg_e                cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i;
  logic signed [PCM_W-1:0] pcm_in_i;
  logic [CODE_W-1:0]       code_in_i;
  logic                    last_in_i;
  logic                    done_o;
  logic [CODE_W-1:0]       code_out_o;
  logic signed [PCM_W-1:0] pcm_out_o;
  logic                    last_out_o;

  codec_scoreboard         sb;
  int unsigned             cycles;

  g711_law_codec_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pcm_in_i    (pcm_in_i),
    .code_in_i   (code_in_i),
    .last_in_i   (last_in_i),
    .done_o      (done_o),
    .code_out_o  (code_out_o),
    .pcm_out_o   (pcm_out_o),
    .last_out_o  (last_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch both ports; every value read here is the one the edge itself sees.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_reg(cfg_idx_i, cfg_wdata_i);
      if (start && !busy) sb.note_word(pcm_in_i, code_in_i, last_in_i);
      if (done_o) sb.check_word(code_out_o, pcm_out_o, last_out_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Hold start high until the word is taken; start stays high for the caller.
  task send_word(logic signed [PCM_W-1:0] pcm, logic [CODE_W-1:0] code, logic last);
    start     <= 1'b1;
    pcm_in_i  <= pcm;
    code_in_i <= code;
    last_in_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task pause(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drop start and wait for the pipeline to empty.
  task settle();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (RESULT_LAT + 2) @(posedge clk_i);
  endtask

  task set_mode(law_e sel, dir_e d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_LAW_SELECT;
    cfg_wdata_i <= sel;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_DIRECTION;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Spread samples over all segments, with extra weight on the mid-scale region.
  function logic signed [PCM_W-1:0] pick_pcm();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0:       return r[15:0];
      3:       return PCM_W'(int'($urandom_range(0, 15)) - 8);
      default: return $signed(r[15:0]) >>> $urandom_range(1, 14);
    endcase
  endfunction

  task directed_words(dir_e d);
    logic signed [PCM_W-1:0] pcm_list [7];
    logic [CODE_W-1:0]       code_list [6];
    pcm_list  = '{16'sh8000, 16'sh8004, -16'sd4, 16'sd0, 16'sd3, 16'sd4, 16'sh7FFF};
    code_list = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hD5};
    if (d == DIR_ENCODE) begin
      foreach (pcm_list[k]) begin
        send_word(pcm_list[k], CODE_W'($urandom), k[0]);
        pause($urandom_range(0, 2));
      end
    end else begin
      foreach (code_list[k]) begin
        send_word(PCM_W'($urandom), code_list[k], k[0]);
        pause($urandom_range(0, 2));
      end
    end
  endtask

  // Bursts of random length with random gaps; now and then a long unbroken stretch.
  task random_words(int unsigned n);
    int unsigned left;
    int unsigned burst;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_word(pick_pcm(), CODE_W'($urandom), 1'($urandom));
      left -= burst;
      pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  initial begin
    law_e sel_seq [8];
    dir_e dir_seq [8];
    sel_seq = '{LAW_MU, LAW_MU, LAW_A, LAW_A, LAW_A, LAW_MU, LAW_MU, LAW_A};
    dir_seq = '{DIR_ENCODE, DIR_DECODE, DIR_ENCODE, DIR_DECODE,
                DIR_ENCODE, DIR_DECODE, DIR_ENCODE, DIR_DECODE};
    sb          = new();
    cycles      = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_LAW_SELECT;
    cfg_wdata_i <= '0;
    pcm_in_i    <= '0;
    code_in_i   <= '0;
    last_in_i   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first phase runs on the reset setting, mu-law encode
    foreach (sel_seq[p]) begin
      if (p > 0) begin
        settle();
        set_mode(sel_seq[p], dir_seq[p]);
      end
      if (p < 4) directed_words(dir_seq[p]);
      random_words(ITEMS_PER_PHASE);
    end

    settle();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d words never came out", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/g711_pkg.sv
rtl/g711_srch_step.sv
rtl/g711_out_stage.sv
rtl/g711_law_codec_unit.sv
verif/g711_law_codec_unit_tb.sv
